[design/lrb_pkg.sv]
// Shared types, codes, constants and the free-space function of the ring index manager.
package lrb_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 3;
    localparam int AMOUNT_W  = 16;
    localparam int OFFSET_W  = 15;
    localparam int FREE_W    = 16;
    localparam int POS_W     = 15;
    localparam int WASTE_W   = 16;
    localparam int SUM_W     = 17;

    localparam int DEFAULT_MAX_DEPTH = 32768;

    localparam logic [CFG_W-1:0] DEPTH_RESET = 16'h8000;
    localparam logic [CFG_W-1:0] MIN_RESET   = 16'd2048;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_DEPTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LINEAR_SIZE = 2'd1;

    typedef enum logic [FUNC_W-1:0] {
        FN_RESERVE_WRITE = 3'd0,
        FN_RESERVE_READ  = 3'd1,
        FN_LINEAR_CHECK  = 3'd2,
        FN_SPACE_CHECK   = 3'd3,
        FN_ADVANCE_WRITE = 3'd4,
        FN_ADVANCE_READ  = 3'd5,
        FN_CLEAR         = 3'd6
    } func_t;

    typedef struct packed {
        logic [CFG_W-1:0] depth;
        logic [CFG_W-1:0] min_size;
        logic [CFG_W-1:0] bound;
    } cfg_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] buffer_offset;
        logic                space_ok;
        logic [FREE_W-1:0]   free_bytes;
        logic [POS_W-1:0]    read_position;
        logic [POS_W-1:0]    write_position;
        logic [WASTE_W-1:0]  waste_length;
    } res_t;

    function automatic logic [CFG_W-1:0] gap_calc(
        input logic [CFG_W-1:0] d,
        input logic [CFG_W-1:0] t,
        input logic [CFG_W-1:0] h
    );
        logic [CFG_W-1:0] diff;
        if (h < t) begin
            return t - h;
        end
        diff = h - t;
        return (diff > d) ? '0 : d - diff;
    endfunction

endpackage

[design/linear_ring_buffer_index_manager_top.sv]
// Top level of the ring index manager: input register, update core and result register.
// Each operation word is held in the input register, passes through the update core and is
// registered as a result word; one word is accepted every cycle while results are taken.
// The rate rests on the update of the read, write and wasted-tail registers in the core
// for each word as it advances, so each word sees the state left by the word before it.
// Configuration writes take effect on the next cycle and leave the indices as they are.
module linear_ring_buffer_index_manager_top #(
    parameter int MAX_DEPTH = lrb_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lrb_pkg::FUNC_W-1:0]    s_func,
    input  logic [lrb_pkg::AMOUNT_W-1:0]  s_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lrb_pkg::OFFSET_W-1:0]  m_buffer_offset,
    output logic                          m_space_ok,
    output logic [lrb_pkg::FREE_W-1:0]    m_free_bytes,
    output logic [lrb_pkg::POS_W-1:0]     m_read_position,
    output logic [lrb_pkg::POS_W-1:0]     m_write_position,
    output logic [lrb_pkg::WASTE_W-1:0]   m_waste_length
);
    import lrb_pkg::*;

    cfg_t cfg;
    res_t res;

    logic                in_valid_reg, in_valid_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [AMOUNT_W-1:0] amount_reg, amount_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;
    logic                advance;
    logic                take;

    lrb_cfg #(.MAX_DEPTH(MAX_DEPTH)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrb_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .func    (func_reg),
        .amount  (amount_reg),
        .res     (res)
    );

    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        take    = s_valid && s_ready;

        in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        func_next     = take ? s_func : func_reg;
        amount_next   = take ? s_amount : amount_reg;

        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        out_next       = advance ? res : out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        amount_reg <= amount_next;
        out_reg    <= out_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_buffer_offset  = out_reg.buffer_offset;
    assign m_space_ok       = out_reg.space_ok;
    assign m_free_bytes     = out_reg.free_bytes;
    assign m_read_position  = out_reg.read_position;
    assign m_write_position = out_reg.write_position;
    assign m_waste_length   = out_reg.waste_length;

`ifndef SYNTHESIS
    a_word_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(func_reg) && $stable(amount_reg))
        else $error("queued word dropped while stalled");

    a_result_follows_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced word produced no result");

    a_result_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result lost before it was taken");
`endif

endmodule

[design/lrb_cfg.sv]
// Configuration registers and the effective depth, minimum size and boundary.
module lrb_cfg #(
    parameter int MAX_DEPTH = lrb_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrb_pkg::CFG_W-1:0]    cfg_data,
    output lrb_pkg::cfg_t                cfg
);
    import lrb_pkg::*;

    localparam logic [CFG_W-1:0] MAX_D = CFG_W'(MAX_DEPTH);

    logic [CFG_W-1:0] depth_reg, depth_next;
    logic [CFG_W-1:0] min_reg, min_next;
    logic [CFG_W-1:0] eff_depth, min_floor, eff_min;

    always_comb begin
        depth_next = depth_reg;
        min_next   = min_reg;
        if (cfg_wr_en) begin
            if (cfg_index == REG_BUFFER_DEPTH) begin
                depth_next = cfg_data;
            end else if (cfg_index == REG_MIN_LINEAR_SIZE) begin
                min_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= DEPTH_RESET;
            min_reg   <= MIN_RESET;
        end else begin
            depth_reg <= depth_next;
            min_reg   <= min_next;
        end
    end

    always_comb begin
        eff_depth = (depth_reg == '0 || depth_reg > MAX_D) ? MAX_D : depth_reg;
        min_floor = (min_reg == '0) ? CFG_W'(1) : min_reg;
        eff_min   = (min_floor > eff_depth) ? eff_depth : min_floor;
        cfg.depth    = eff_depth;
        cfg.min_size = eff_min;
        cfg.bound    = eff_depth - eff_min;
    end

endmodule

[design/lrb_core.sv]
// Index state and the combinational update for one operation word, registered on each step.
module lrb_core #(
    parameter int MAX_DEPTH = lrb_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrb_pkg::cfg_t                cfg,
    input  logic                         step,
    input  logic [lrb_pkg::FUNC_W-1:0]   func,
    input  logic [lrb_pkg::AMOUNT_W-1:0] amount,
    output lrb_pkg::res_t                res
);
    import lrb_pkg::*;

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int WT_W  = $clog2(MAX_DEPTH + 1);

    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] w_reg, w_next;
    logic [WT_W-1:0]  wt_reg, wt_next;

    logic [CFG_W-1:0] d, m, bound, r16, w16, offset;
    logic [SUM_W-1:0] s, s2, tail;
    logic             ok;

    always_comb begin
        d      = cfg.depth;
        m      = cfg.min_size;
        bound  = cfg.bound;
        r16    = CFG_W'(r_reg);
        w16    = CFG_W'(w_reg);
        r_next  = r_reg;
        w_next  = w_reg;
        wt_next = wt_reg;
        offset = '0;
        ok     = 1'b0;
        s      = '0;
        s2     = '0;
        tail   = '0;
        unique case (func_t'(func))
            FN_RESERVE_WRITE: begin
                if (w16 >= r16 && (w16 >= d || d - w16 < m)) begin
                    w_next = '0;
                end
                offset = CFG_W'(w_next);
            end
            FN_RESERVE_READ: begin
                if (r16 > bound) begin
                    if (wt_reg == '0) begin
                        wt_next = (r16 < d) ? WT_W'(d - r16) : '0;
                    end
                end else begin
                    offset = r16;
                end
            end
            FN_LINEAR_CHECK: begin
                ok = 1'b1;
                if (gap_calc(d, r16, w16) < m) begin
                    ok = 1'b0;
                end else if (w16 >= d || d - w16 < m) begin
                    if (gap_calc(d, r16, '0) < m) begin
                        ok = 1'b0;
                    end
                end
            end
            FN_SPACE_CHECK: begin
                ok = (gap_calc(d, r16, w16) >= amount);
            end
            FN_ADVANCE_WRITE: begin
                s = SUM_W'(w16) + SUM_W'(amount);
                w_next = (s > SUM_W'(bound)) ? '0 : IDX_W'(s);
            end
            FN_ADVANCE_READ: begin
                s = SUM_W'(r16) + SUM_W'(amount);
                if (s > SUM_W'(bound) && s >= SUM_W'(w16)) begin
                    if (wt_reg != '0) begin
                        s2   = s + SUM_W'(wt_reg);
                        tail = (s2 >= SUM_W'(d)) ? s2 - SUM_W'(d) : '0;
                        wt_next = '0;
                    end else begin
                        tail = '0;
                    end
                    if (w16 > bound) begin
                        w_next = '0;
                    end
                end else begin
                    tail = s;
                end
                r_next = (tail >= SUM_W'(d)) ? '0 : IDX_W'(tail);
            end
            FN_CLEAR: begin
                r_next  = '0;
                w_next  = '0;
                wt_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg  <= '0;
            w_reg  <= '0;
            wt_reg <= '0;
        end else if (step) begin
            r_reg  <= r_next;
            w_reg  <= w_next;
            wt_reg <= wt_next;
        end
    end

    always_comb begin
        res.buffer_offset  = OFFSET_W'(offset);
        res.space_ok       = ok;
        res.free_bytes     = gap_calc(d, CFG_W'(r_next), CFG_W'(w_next));
        res.read_position  = POS_W'(r_next);
        res.write_position = POS_W'(w_next);
        res.waste_length   = WASTE_W'(wt_next);
    end

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FN_CLEAR |=> r_reg == '0 && w_reg == '0 && wt_reg == '0)
        else $error("clear left index state non-zero");

    a_write_within_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FN_ADVANCE_WRITE |=> CFG_W'(w_reg) <= $past(cfg.bound))
        else $error("write advance went past boundary");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(r_reg) && $stable(w_reg) && $stable(wt_reg))
        else $error("index state changed without an operation");
`endif

endmodule

[tb/tb_linear_ring_buffer_index_manager_top.sv]
// Self-checking testbench for the ring buffer index manager: queued stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_linear_ring_buffer_index_manager_top;
    import lrb_pkg::*;

    localparam int unsigned MAX_DEPTH = DEFAULT_MAX_DEPTH;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
    localparam int MAX_WAIT = 13;

    typedef enum logic [1:0] {
        STEP_OP,
        STEP_CFG,
        STEP_DRAIN
    } plan_kind_t;

    typedef struct {
        plan_kind_t             kind;
        logic [FUNC_W-1:0]      fn;
        logic [AMOUNT_W-1:0]    amt;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
    } plan_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func = '0;
    logic [AMOUNT_W-1:0]  s_amount = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OFFSET_W-1:0]  m_buffer_offset;
    logic                 m_space_ok;
    logic [FREE_W-1:0]    m_free_bytes;
    logic [POS_W-1:0]     m_read_position;
    logic [POS_W-1:0]     m_write_position;
    logic [WASTE_W-1:0]   m_waste_length;

    plan_t pending_words[$];
    res_t  due_results[$];
    res_t  want_res;

    logic [CFG_W-1:0] depth_reg = DEPTH_RESET;
    logic [CFG_W-1:0] min_reg   = MIN_RESET;
    int unsigned      rd_idx    = 0;
    int unsigned      wr_idx    = 0;
    int unsigned      waste     = 0;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  send_calm      = 1'b0;
    bit  recv_calm      = 1'b0;
    bit  word_taken     = 1'b0;
    bit  result_taken   = 1'b0;
    int  send_wait      = -1;
    int  recv_wait      = -1;

    logic                 nx_valid;
    logic [FUNC_W-1:0]    nx_func;
    logic [AMOUNT_W-1:0]  nx_amount;
    logic                 nx_wr;
    logic [CFG_IDX_W-1:0] nx_idx;
    logic [CFG_W-1:0]     nx_data;
    logic                 nx_ready;

    int unsigned plan_d = MAX_DEPTH;
    int unsigned plan_m = 2048;

    linear_ring_buffer_index_manager_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_amount         (s_amount),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_buffer_offset  (m_buffer_offset),
        .m_space_ok       (m_space_ok),
        .m_free_bytes     (m_free_bytes),
        .m_read_position  (m_read_position),
        .m_write_position (m_write_position),
        .m_waste_length   (m_waste_length)
    );

    function automatic int unsigned ring_gap(input int unsigned d, input int unsigned t,
                                             input int unsigned h);
        if (h < t) begin
            return t - h;
        end
        return ((h - t) > d) ? 0 : d - (h - t);
    endfunction

    function automatic res_t step_indices(input logic [FUNC_W-1:0] fn,
                                          input logic [AMOUNT_W-1:0] amt);
        int unsigned d;
        int unsigned m;
        int unsigned bound;
        int unsigned offset;
        int unsigned ok;
        int unsigned r;
        int unsigned w;
        int unsigned s;
        int unsigned free;
        res_t        res;
        d = depth_reg;
        if (d == 0 || d > MAX_DEPTH) begin
            d = MAX_DEPTH;
        end
        m = min_reg;
        if (m == 0) begin
            m = 1;
        end
        if (m > d) begin
            m = d;
        end
        bound  = d - m;
        offset = 0;
        ok     = 0;
        r      = rd_idx;
        w      = wr_idx;
        case (fn)
            FN_RESERVE_WRITE: begin
                if (w >= r && (w >= d || d - w < m)) begin
                    wr_idx = 0;
                end
                offset = wr_idx;
            end
            FN_RESERVE_READ: begin
                if (r > bound) begin
                    if (waste == 0) begin
                        waste = (r < d) ? d - r : 0;
                    end
                end else begin
                    offset = r;
                end
            end
            FN_LINEAR_CHECK: begin
                ok = 1;
                if (ring_gap(d, r, w) < m) begin
                    ok = 0;
                end else if (w >= d || d - w < m) begin
                    if (ring_gap(d, r, 0) < m) begin
                        ok = 0;
                    end
                end
            end
            FN_SPACE_CHECK: begin
                ok = (ring_gap(d, r, w) >= amt) ? 1 : 0;
            end
            FN_ADVANCE_WRITE: begin
                s = w + amt;
                wr_idx = (s > bound) ? 0 : s;
            end
            FN_ADVANCE_READ: begin
                s = r + amt;
                if (s > bound && s >= w) begin
                    if (waste != 0) begin
                        s = s + waste;
                        s = (s >= d) ? s - d : 0;
                        waste = 0;
                    end else begin
                        s = 0;
                    end
                    if (w > bound) begin
                        wr_idx = 0;
                    end
                end
                rd_idx = (s >= d) ? 0 : s;
            end
            FN_CLEAR: begin
                rd_idx = 0;
                wr_idx = 0;
                waste  = 0;
            end
            default: begin
            end
        endcase
        free = ring_gap(d, rd_idx, wr_idx);
        res.buffer_offset  = offset[OFFSET_W-1:0];
        res.space_ok       = ok[0];
        res.free_bytes     = free[FREE_W-1:0];
        res.read_position  = rd_idx[POS_W-1:0];
        res.write_position = wr_idx[POS_W-1:0];
        res.waste_length   = waste[WASTE_W-1:0];
        return res;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic add_op(input logic [FUNC_W-1:0] fn, input logic [AMOUNT_W-1:0] amt);
        plan_t p;
        p.kind = STEP_OP;
        p.fn   = fn;
        p.amt  = amt;
        p.idx  = '0;
        p.data = '0;
        pending_words.push_back(p);
    endtask

    task automatic add_drain();
        plan_t p;
        p.kind = STEP_DRAIN;
        p.fn   = '0;
        p.amt  = '0;
        p.idx  = '0;
        p.data = '0;
        pending_words.push_back(p);
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] depth, input logic [CFG_W-1:0] min_size);
        plan_t p;
        p.kind = STEP_CFG;
        p.fn   = '0;
        p.amt  = '0;
        p.idx  = REG_BUFFER_DEPTH;
        p.data = depth;
        pending_words.push_back(p);
        p.idx  = REG_MIN_LINEAR_SIZE;
        p.data = min_size;
        pending_words.push_back(p);
        plan_d = depth;
        if (plan_d == 0 || plan_d > MAX_DEPTH) begin
            plan_d = MAX_DEPTH;
        end
        plan_m = (min_size == 0) ? 1 : min_size;
        if (plan_m > plan_d) begin
            plan_m = plan_d;
        end
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return AMOUNT_W'($urandom);
            2: return AMOUNT_W'(plan_d);
            3: return AMOUNT_W'(plan_m);
            4, 5: return AMOUNT_W'($urandom_range(0, plan_m));
            default: return AMOUNT_W'($urandom_range(0, plan_d));
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // check results, track configuration, predict on accepted words
    always @(posedge aclk) begin
        if (aresetn) begin
            cycle_count++;
            if (cycle_count % 300 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            if (m_valid && m_ready) begin
                result_taken = 1'b1;
                if (due_results.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    mismatch_count++;
                end else begin
                    want_res = due_results.pop_front();
                    check_field("buffer_offset", want_res.buffer_offset, m_buffer_offset);
                    check_field("space_ok", want_res.space_ok, m_space_ok);
                    check_field("free_bytes", want_res.free_bytes, m_free_bytes);
                    check_field("read_position", want_res.read_position, m_read_position);
                    check_field("write_position", want_res.write_position, m_write_position);
                    check_field("waste_length", want_res.waste_length, m_waste_length);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BUFFER_DEPTH:    depth_reg = cfg_data;
                    REG_MIN_LINEAR_SIZE: min_reg   = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                word_taken = 1'b1;
                due_results.push_back(step_indices(s_func, s_amount));
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            nx_valid   = s_valid && !word_taken;
            nx_func    = s_func;
            nx_amount  = s_amount;
            nx_wr      = 1'b0;
            nx_idx     = cfg_index;
            nx_data    = cfg_data;
            word_taken = 1'b0;
            if (!nx_valid) begin
                if (send_wait < 0) begin
                    send_wait = draw_wait(send_calm);
                end
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_words.size() != 0) begin
                    case (pending_words[0].kind)
                        STEP_OP: begin
                            nx_valid  = 1'b1;
                            nx_func   = pending_words[0].fn;
                            nx_amount = pending_words[0].amt;
                            void'(pending_words.pop_front());
                            send_wait = -1;
                        end
                        STEP_CFG: begin
                            if (due_results.size() == 0) begin
                                nx_wr   = 1'b1;
                                nx_idx  = pending_words[0].idx;
                                nx_data = pending_words[0].data;
                                void'(pending_words.pop_front());
                            end
                        end
                        default: begin
                            if (due_results.size() == 0) begin
                                void'(pending_words.pop_front());
                            end
                        end
                    endcase
                end
            end
            s_valid   <= nx_valid;
            s_func    <= nx_func;
            s_amount  <= nx_amount;
            cfg_wr_en <= nx_wr;
            cfg_index <= nx_idx;
            cfg_data  <= nx_data;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!m_ready || result_taken) begin
                result_taken = 1'b0;
                if (recv_wait < 0) begin
                    recv_wait = draw_wait(recv_calm);
                end
                if (recv_wait > 0) begin
                    recv_wait--;
                    nx_ready = 1'b0;
                end else begin
                    nx_ready  = 1'b1;
                    recv_wait = -1;
                end
                m_ready <= nx_ready;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0]    phase_depth [12];
        logic [CFG_W-1:0]    phase_min [12];
        logic [AMOUNT_W-1:0] a;
        int                  made;

        add_op(FN_CLEAR, '0);
        add_op(FN_LINEAR_CHECK, '0);
        add_op(FN_SPACE_CHECK, 16'h8000);
        add_op(FN_SPACE_CHECK, 16'hFFFF);
        add_op(FN_UNUSED, 16'hFFFF);
        add_op(FN_ADVANCE_WRITE, 16'd30720);
        add_op(FN_RESERVE_WRITE, '0);
        add_op(FN_ADVANCE_WRITE, 16'd1);
        add_op(FN_ADVANCE_WRITE, 16'd20000);
        add_op(FN_ADVANCE_READ, 16'd20000);
        add_op(FN_SPACE_CHECK, 16'h8000);
        add_cfg(16'h8000, 16'd16384);
        add_op(FN_RESERVE_READ, '0);
        add_op(FN_LINEAR_CHECK, '0);
        add_op(FN_RESERVE_WRITE, '0);
        add_op(FN_ADVANCE_WRITE, 16'd100);
        add_op(FN_ADVANCE_READ, 16'd100);
        add_op(FN_ADVANCE_WRITE, 16'd5000);
        add_cfg(16'd1000, 16'd1);
        add_op(FN_SPACE_CHECK, '0);
        add_op(FN_LINEAR_CHECK, '0);
        add_op(FN_RESERVE_READ, '0);
        add_op(FN_RESERVE_WRITE, '0);
        add_op(FN_ADVANCE_READ, 16'hFFFF);
        add_cfg(16'h8000, 16'd2048);
        add_op(FN_ADVANCE_WRITE, 16'd5000);
        add_op(FN_ADVANCE_READ, 16'd5000);
        add_cfg(16'd1000, 16'd1);
        add_op(FN_RESERVE_READ, '0);
        add_op(FN_ADVANCE_READ, '0);
        add_op(FN_CLEAR, '0);

        phase_depth = '{16'd16, 16'd16, 16'd0, 16'd40000, 16'd1, 16'd100,
                        16'h8000, 16'hFFFF, 16'd0, 16'd0, 16'h8000, 16'd4096};
        phase_min   = '{16'd1, 16'd16, 16'd0, 16'd50000, 16'd1, 16'd30,
                        16'h8000, 16'hFFFF, 16'd0, 16'd0, 16'd2048, 16'd512};
        phase_depth[8] = CFG_W'($urandom_range(16, MAX_DEPTH));
        phase_min[8]   = CFG_W'($urandom_range(1, phase_depth[8]));
        phase_depth[9] = CFG_W'($urandom);
        phase_min[9]   = CFG_W'($urandom);

        for (int ph = 0; ph < 12; ph++) begin
            add_cfg(phase_depth[ph], phase_min[ph]);
            if (ph == 6) begin
                add_drain();
            end
            made = 0;
            if ($urandom_range(0, 1) == 0) begin
                add_op(FN_CLEAR, AMOUNT_W'($urandom));
                made++;
            end
            while (made < 92) begin
                if ($urandom_range(0, 9) < 7) begin
                    a = pick_amount();
                    add_op(FN_RESERVE_WRITE, AMOUNT_W'($urandom));
                    add_op(FN_SPACE_CHECK, a);
                    add_op(FN_ADVANCE_WRITE, a);
                    add_op(FN_LINEAR_CHECK, AMOUNT_W'($urandom));
                    add_op(FN_RESERVE_READ, AMOUNT_W'($urandom));
                    add_op(FN_ADVANCE_READ, ($urandom_range(0, 3) == 0) ? pick_amount() : a);
                    made += 6;
                end else begin
                    add_op(FUNC_W'($urandom_range(0, 7)), pick_amount());
                    made++;
                end
            end
        end

        while (pending_words.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
